// File: sv/lfu_pkg.sv
// Shared constants, default parameter values and types of the LFU cache core.
// Depends on nothing; every other file of the core imports it.
`timescale 1ns / 1ps

package lfu_pkg;

	// Default sizes of the store.
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	// Capacity register.
	localparam int              CAP_BITS  = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// Operation codes carried in the mode field.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Write enables of the entry store, one per field.
	typedef struct packed {
		logic key;
		logic value;
		logic count;
		logic rank;
	} lfu_wr_en_t;

endpackage

// File: sv/lfu_cfg_if.sv
// Configuration write channel of the LFU cache core: the capacity register.
// Depends on lfu_pkg for the register width.
`timescale 1ns / 1ps

interface lfu_cfg_if import lfu_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [CAP_BITS-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

// File: sv/lfu_req_if.sv
// Request channel of the LFU cache core: one get or put transaction.
// Depends on lfu_pkg for the default field widths.
`timescale 1ns / 1ps

interface lfu_req_if import lfu_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] write_value;

	modport source (output valid, output mode, output lookup_key, output write_value,
		input ready);
	modport sink   (input valid, input mode, input lookup_key, input write_value,
		output ready);
endinterface

// File: sv/lfu_rsp_if.sv
// Response channel of the LFU cache core: the result of one transaction.
// Depends on lfu_pkg for the default field widths.
`timescale 1ns / 1ps

interface lfu_rsp_if import lfu_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;
	logic [KEY_BITS-1:0]   evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink   (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

// File: sv/lfu_entry_store.sv
// Entry store of the LFU cache core: key, value, use count and recency rank memories.
// One shared registered read port; one write port for key, value and count, one for ranks; depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_entry_store import lfu_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                  clk,
	input  logic [AW-1:0]         rd_addr,
	output logic [KEY_BITS-1:0]   rd_key,
	output logic [VALUE_BITS-1:0] rd_value,
	output logic [COUNT_BITS-1:0] rd_count,
	output logic [AW-1:0]         rd_rank,
	input  lfu_wr_en_t            wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic [COUNT_BITS-1:0] wr_count,
	input  logic [AW-1:0]         rank_wr_addr,
	input  logic [AW-1:0]         wr_rank
);

	logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
	logic [VALUE_BITS-1:0] value_mem [ENTRIES];
	logic [COUNT_BITS-1:0] count_mem [ENTRIES];
	logic [AW-1:0]         rank_mem  [ENTRIES];

	// Writes of the entry fields share one address; ranks have their own.
	always_ff @(posedge clk) begin
		if (wr_en.key) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_en.value) begin
			value_mem[wr_addr] <= wr_value;
		end
		if (wr_en.count) begin
			count_mem[wr_addr] <= wr_count;
		end
		if (wr_en.rank) begin
			rank_mem[rank_wr_addr] <= wr_rank;
		end
	end

	// Registered read of all fields of one entry.
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
		rd_count <= count_mem[rd_addr];
		rd_rank  <= rank_mem[rd_addr];
	end

endmodule

// File: sv/lfu_cache_lookup_replace_core.sv
// LFU cache core, top level: sequencer, scan compare unit and result register.
// Depends on lfu_pkg, the three channel interfaces and lfu_entry_store.
`timescale 1ns / 1ps

// Fully associative key/value cache with least-frequently-used replacement and
// least-recently-used tie-break. One transaction at a time: the single read port
// of the entry store sets the pace. A first pass reads every held entry once to
// find the key and the replacement victim together; when the transaction
// updates the store (anything but a get miss or a put with capacity zero), a
// second pass reads and rewrites every recency rank. Each pass ends by draining
// the read pipeline.
// Held entries always occupy slots 0 to N-1, so no per-entry valid bits or
// clearing pass are needed after reset. A finished result waits in its own
// register, and the next request is taken while it waits. Capacity is written
// through the configuration channel, which is always ready; values above
// ENTRIES act as ENTRIES, and zero turns every put into a pure lookup.

module lfu_cache_lookup_replace_core import lfu_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lfu_cfg_if.sink      cfg,
	lfu_req_if.sink      req,
	lfu_rsp_if.source    rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_DECIDE  = 5'b00100,
		ST_PROMOTE = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [CW-1:0]         held_q;

	// Latched request.
	logic                  mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// Scan control.
	logic [CW-1:0]         idx_q;
	logic                  chk_vld_q;
	logic [AW-1:0]         chk_idx_q;
	logic                  issue;

	// Lookup and victim trackers.
	logic                  found_q;
	logic [AW-1:0]         found_idx_q;
	logic [AW-1:0]         found_rank_q;
	logic [COUNT_BITS-1:0] found_cnt_q;
	logic [VALUE_BITS-1:0] found_val_q;
	logic                  vic_vld_q;
	logic [AW-1:0]         vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [AW-1:0]         vic_rank_q;
	logic [KEY_BITS-1:0]   vic_key_q;

	// Promotion parameters.
	logic [AW-1:0]         tgt_idx_q;
	logic [CW-1:0]         limit_q;

	// Pending result and output register.
	logic                  res_hit_q;
	logic [VALUE_BITS-1:0] res_rv_q;
	logic                  res_ev_q;
	logic [KEY_BITS-1:0]   res_evk_q;
	logic                  out_vld_q;
	logic                  out_hit_q;
	logic [VALUE_BITS-1:0] out_rv_q;
	logic                  out_ev_q;
	logic [KEY_BITS-1:0]   out_evk_q;

	// Store ports.
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_value;
	logic [COUNT_BITS-1:0] rd_count;
	logic [AW-1:0]         rd_rank;
	lfu_wr_en_t            wr_en;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_count;
	logic [AW-1:0]         wr_rank;

	// Decision signals.
	logic [31:0]           cap_wide;
	logic [CW-1:0]         cap_eff;
	logic                  no_change;
	logic                  fill;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  take_vic;
	logic                  fin_go;
	logic                  req_fire;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;

	assign rsp.valid       = out_vld_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.read_value  = out_rv_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_evk_q;

	// Effective capacity is the register clipped to the number of entries.
	assign cap_wide = {{(32 - CAP_BITS){1'b0}}, cap_q};
	assign cap_eff  = (cap_wide < ENTRIES) ? cap_wide[CW-1:0] : ENTRIES_C;

	// A scan pass reads the held entries in order, one per cycle.
	assign issue = ((state_q == ST_SCAN) || (state_q == ST_PROMOTE)) && (idx_q < held_q);

	assign no_change = (mode_q == OP_GET) ? !found_q : (cap_eff == '0);
	assign fill      = !found_q && (held_q < cap_eff);
	assign cnt_inc   = (found_cnt_q == COUNT_MAX) ? found_cnt_q : found_cnt_q + COUNT_ONE;
	assign fin_go    = !out_vld_q || rsp.ready;

	// Victim compare: smaller count wins, the older entry wins a tie.
	assign take_vic = !vic_vld_q || (rd_count < vic_cnt_q) ||
		((rd_count == vic_cnt_q) && (rd_rank > vic_rank_q));

	// Store writes: entry fields in the decision cycle, ranks during promotion.
	always_comb begin
		wr_en    = '0;
		wr_addr  = found_q ? found_idx_q : (fill ? held_q[AW-1:0] : vic_idx_q);
		wr_count = found_q ? cnt_inc : COUNT_ONE;
		wr_rank  = rd_rank;
		if ((state_q == ST_DECIDE) && !no_change) begin
			wr_en.count = 1'b1;
			wr_en.value = (mode_q == OP_PUT);
			wr_en.key   = !found_q;
		end
		if ((state_q == ST_PROMOTE) && chk_vld_q) begin
			wr_en.rank = 1'b1;
			if (chk_idx_q == tgt_idx_q) begin
				wr_rank = '0;
			end else if ({{(CW - AW){1'b0}}, rd_rank} < limit_q) begin
				wr_rank = rd_rank + AW'(1);
			end
		end
	end

	lfu_entry_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk          (clk),
		.rd_addr      (idx_q[AW-1:0]),
		.rd_key       (rd_key),
		.rd_value     (rd_value),
		.rd_count     (rd_count),
		.rd_rank      (rd_rank),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_key       (key_q),
		.wr_value     (val_q),
		.wr_count     (wr_count),
		.rank_wr_addr (chk_idx_q),
		.wr_rank      (wr_rank)
	);

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.capacity;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			held_q    <= '0;
			idx_q     <= '0;
			chk_vld_q <= 1'b0;
			found_q   <= 1'b0;
			vic_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// The output register loads a new result or empties on a transaction.
			if ((state_q == ST_FINISH) && fin_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			chk_vld_q <= issue;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						idx_q     <= '0;
						found_q   <= 1'b0;
						vic_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chk_vld_q) begin
						if (!found_q && (rd_key == key_q)) begin
							found_q <= 1'b1;
						end
						if (take_vic) begin
							vic_vld_q <= 1'b1;
						end
					end
					if (!issue && !chk_vld_q) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (no_change) begin
						state_q <= ST_FINISH;
					end else begin
						if (fill) begin
							held_q <= held_q + CW'(1);
						end
						state_q <= ST_PROMOTE;
					end
				end
				ST_PROMOTE: begin
					if (!issue && !chk_vld_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request, scan trackers, promotion setup and results.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q <= req.mode;
			key_q  <= req.lookup_key;
			val_q  <= req.write_value;
		end
		if (issue) begin
			chk_idx_q <= idx_q[AW-1:0];
		end
		if ((state_q == ST_SCAN) && chk_vld_q) begin
			if (!found_q && (rd_key == key_q)) begin
				found_idx_q  <= chk_idx_q;
				found_rank_q <= rd_rank;
				found_cnt_q  <= rd_count;
				found_val_q  <= rd_value;
			end
			if (take_vic) begin
				vic_idx_q  <= chk_idx_q;
				vic_cnt_q  <= rd_count;
				vic_rank_q <= rd_rank;
				vic_key_q  <= rd_key;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_hit_q <= found_q;
			res_rv_q  <= ((mode_q == OP_GET) && found_q) ? found_val_q : '0;
			res_ev_q  <= !no_change && !found_q && !fill;
			res_evk_q <= (!no_change && !found_q && !fill) ? vic_key_q : '0;
			tgt_idx_q <= wr_addr;
			if (found_q) begin
				limit_q <= {{(CW - AW){1'b0}}, found_rank_q};
			end else if (fill) begin
				limit_q <= held_q + CW'(1);
			end else begin
				limit_q <= {{(CW - AW){1'b0}}, vic_rank_q};
			end
		end
		if ((state_q == ST_FINISH) && fin_go) begin
			out_hit_q <= res_hit_q;
			out_rv_q  <= res_rv_q;
			out_ev_q  <= res_ev_q;
			out_evk_q <= res_evk_q;
		end
	end

endmodule

// File: test/lfu_cache_lookup_replace_core_test.sv
// Self-checking testbench of the LFU cache core: directed and random get/put traffic.
// Depends on lfu_pkg, the three channel interfaces and lfu_cache_lookup_replace_core.
`timescale 1ns / 1ps

module lfu_cache_lookup_replace_core_test;
	import lfu_pkg::*;

	localparam int ENTRIES    = ENTRIES_DEF;
	localparam int KEY_BITS   = KEY_BITS_DEF;
	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam int COUNT_BITS = COUNT_BITS_DEF;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 20;

	typedef struct packed {
		logic                  mode;
		logic [KEY_BITS-1:0]   lookup_key;
		logic [VALUE_BITS-1:0] write_value;
	} cache_op_t;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
	} cache_rsp_t;

	logic clk;
	logic arst_n;

	lfu_cfg_if cfg_ch ();
	lfu_req_if req_ch ();
	lfu_rsp_if rsp_ch ();

	lfu_cache_lookup_replace_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the cache contents.
	bit                    ent_valid [ENTRIES];
	logic [KEY_BITS-1:0]   ent_key   [ENTRIES];
	logic [VALUE_BITS-1:0] ent_value [ENTRIES];
	logic [COUNT_BITS-1:0] ent_uses  [ENTRIES];
	int unsigned           ent_age   [ENTRIES];
	int unsigned           held_entries;
	logic [CAP_BITS-1:0]   shadow_capacity;

	cache_op_t  pending_ops [$];
	cache_rsp_t expected_rsps [$];
	cache_op_t  next_op;
	cache_op_t  accepted_op;
	cache_rsp_t predicted_rsp;
	cache_rsp_t observed_rsp;

	int  items_sent;
	int  results_seen;
	int  mismatch_count;
	int  src_idle_pct;
	int  sink_idle_pct;
	int  hold_request;
	int  hold_left;
	bit  req_taken;

	logic [KEY_BITS-1:0] key_pool [32];
	int                  pool_size;

	// Free-running clock.
	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// Watchdog for a hung run.
	initial begin
		#50_000_000;
		$display("lfu_cache_lookup_replace_core_test: done, errors");
		$finish;
	end

	// Make entry e the most recent; valid entries younger than limit age by one.
	task automatic make_recent(input int e, input int unsigned limit);
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			if (ent_valid[i] && i != e && ent_age[i] < limit) begin
				ent_age[i]++;
			end
		end
		ent_age[e] = 0;
	endtask

	// Count one use of entry e, saturating, and make it the most recent.
	task automatic count_use(input int e);
		if (ent_uses[e] != '1) begin
			ent_uses[e]++;
		end
		make_recent(e, ent_age[e]);
	endtask

	// Compute the response of one get or put and update the shadow cache.
	task automatic predict_lookup(input cache_op_t op, output cache_rsp_t r);
		int          i;
		int          found;
		int          slot;
		int          victim;
		int unsigned eff_cap;
		r = '0;
		found = -1;
		slot = -1;
		victim = -1;
		eff_cap = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
		for (i = 0; i < ENTRIES; i++) begin
			if (found < 0 && ent_valid[i] && ent_key[i] == op.lookup_key) begin
				found = i;
			end
		end
		r.hit = (found >= 0);
		if (op.mode == OP_GET) begin
			if (found >= 0) begin
				r.read_value = ent_value[found];
				count_use(found);
			end
		end else if (eff_cap != 0) begin
			if (found >= 0) begin
				ent_value[found] = op.write_value;
				count_use(found);
			end else if (held_entries < eff_cap) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (slot < 0 && !ent_valid[i]) begin
						slot = i;
					end
				end
				ent_valid[slot] = 1'b1;
				ent_key[slot] = op.lookup_key;
				ent_value[slot] = op.write_value;
				ent_uses[slot] = COUNT_BITS'(1);
				held_entries++;
				make_recent(slot, held_entries);
			end else begin
				// Victim: fewest uses, oldest among equal counts.
				for (i = 0; i < ENTRIES; i++) begin
					if (ent_valid[i] && (victim < 0 || ent_uses[i] < ent_uses[victim] ||
							(ent_uses[i] == ent_uses[victim] &&
							ent_age[i] > ent_age[victim]))) begin
						victim = i;
					end
				end
				r.evicted = 1'b1;
				r.evicted_key = ent_key[victim];
				ent_key[victim] = op.lookup_key;
				ent_value[victim] = op.write_value;
				ent_uses[victim] = COUNT_BITS'(1);
				make_recent(victim, ent_age[victim]);
			end
		end
	endtask

	task automatic push_op(input logic mode, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] value);
		cache_op_t op;
		op.mode = mode;
		op.lookup_key = key;
		op.write_value = value;
		pending_ops.push_back(op);
		items_sent++;
	endtask

	// Wait until every transaction has its response, then let the core go quiet.
	task automatic settle();
		while (results_seen != items_sent) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the capacity register; only called while the core is idle.
	task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity <= cap;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		shadow_capacity = cap;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random gets and puts over a small pool of keys, with some stray keys.
	task automatic run_random(input int count, input int pool_n);
		int i;
		logic [KEY_BITS-1:0] key;
		pool_size = pool_n;
		for (i = 0; i < pool_n; i++) begin
			key_pool[i] = $urandom;
		end
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				key = $urandom;
			end else begin
				key = key_pool[$urandom_range(0, pool_size - 1)];
			end
			push_op(logic'($urandom_range(0, 1)), key, $urandom);
		end
	endtask

	// Request driver: a new transaction is offered once the current one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				next_op = pending_ops.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.mode <= next_op.mode;
				req_ch.lookup_key <= next_op.lookup_key;
				req_ch.write_value <= next_op.write_value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// Response ready, with random stalls and an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Check responses against the oldest prediction, then predict accepted requests.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			observed_rsp.hit = rsp_ch.hit;
			observed_rsp.read_value = rsp_ch.read_value;
			observed_rsp.evicted = rsp_ch.evicted;
			observed_rsp.evicted_key = rsp_ch.evicted_key;
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: response with no transaction pending: hit %0b value %h evicted %0b key %h",
						$time, observed_rsp.hit, observed_rsp.read_value,
						observed_rsp.evicted, observed_rsp.evicted_key);
				end
			end else begin
				predicted_rsp = expected_rsps.pop_front();
				if (observed_rsp.hit !== predicted_rsp.hit ||
						observed_rsp.read_value !== predicted_rsp.read_value ||
						observed_rsp.evicted !== predicted_rsp.evicted ||
						observed_rsp.evicted_key !== predicted_rsp.evicted_key) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: mismatch: expected hit %0b value %h evicted %0b key %h, got hit %0b value %h evicted %0b key %h",
							$time, predicted_rsp.hit, predicted_rsp.read_value,
							predicted_rsp.evicted, predicted_rsp.evicted_key,
							observed_rsp.hit, observed_rsp.read_value,
							observed_rsp.evicted, observed_rsp.evicted_key);
					end
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			accepted_op.mode = req_ch.mode;
			accepted_op.lookup_key = req_ch.lookup_key;
			accepted_op.write_value = req_ch.write_value;
			predict_lookup(accepted_op, predicted_rsp);
			expected_rsps.push_back(predicted_rsp);
			req_taken = 1'b1;
		end
	end

	// Test sequence.
	initial begin
		int i;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.capacity = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = OP_GET;
		req_ch.lookup_key = '0;
		req_ch.write_value = '0;
		rsp_ch.ready = 1'b0;
		for (i = 0; i < ENTRIES; i++) begin
			ent_valid[i] = 1'b0;
			ent_key[i] = '0;
			ent_value[i] = '0;
			ent_uses[i] = '0;
			ent_age[i] = 0;
		end
		held_entries = 0;
		shadow_capacity = CAP_RESET;
		items_sent = 0;
		results_seen = 0;
		mismatch_count = 0;
		src_idle_pct = 8;
		sink_idle_pct = 56;
		hold_request = 0;
		hold_left = 0;
		req_taken = 1'b0;
		pool_size = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Get miss on an empty cache at the reset capacity.
		push_op(OP_GET, '0, '1);
		write_capacity(2);

		// Raise one entry's use count well above a fresh entry's, then check
		// that it survives an eviction choice against a fresh entry.
		push_op(OP_PUT, '1, '1);
		for (i = 0; i < 16; i++) begin
			push_op(OP_GET, '1, '0);
		end
		push_op(OP_PUT, '0, '0);
		push_op(OP_PUT, '1, 32'h1234_5678);
		push_op(OP_GET, '1, '1);
		push_op(OP_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		push_op(OP_GET, '0, '0);
		push_op(OP_GET, 32'hA5A5_A5A5, '0);

		// Capacity lowered below the number of held entries.
		write_capacity(1);
		push_op(OP_PUT, 32'h0000_0001, 32'h0000_0001);
		push_op(OP_GET, 32'hA5A5_A5A5, '0);

		// Capacity zero: puts only report presence.
		write_capacity(0);
		push_op(OP_PUT, 32'h0000_0002, '1);
		push_op(OP_PUT, '1, '0);
		push_op(OP_GET, '1, '0);

		// Capacity above the entry count: fill every entry, then evict.
		write_capacity(31);
		for (i = 0; i < 15; i++) begin
			push_op(OP_PUT, 32'h8000_0000 + i, $urandom);
		end
		push_op(OP_GET, 32'h8000_0003, '0);

		// Sender mostly busy, receiver often stalled, with one long hold-off.
		src_idle_pct = 8;
		sink_idle_pct = 56;
		write_capacity(16);
		run_random(90, 22);
		hold_request = 300;
		settle();
		run_random(20, 22);
		write_capacity(5);
		run_random(70, 10);

		// Sender often idle, receiver mostly ready.
		src_idle_pct = 56;
		sink_idle_pct = 8;
		write_capacity(20);
		run_random(80, 24);
		write_capacity(3);
		run_random(80, 7);

		// No idling on either side.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		write_capacity(16);
		run_random(60, 20);
		write_capacity(0);
		run_random(30, 20);
		write_capacity(1);
		run_random(40, 3);
		write_capacity(16);
		run_random(40, 24);
		settle();

		if (mismatch_count == 0) begin
			$display("lfu_cache_lookup_replace_core_test: done, clean");
		end else begin
			$display("lfu_cache_lookup_replace_core_test: done, errors");
		end
		$finish;
	end

endmodule
